@@ hw/rtl/ptrn_pkg.sv @@
// ptrn_pkg: shared constants, answer descriptor type and fallback name table
// for the reverse-lookup name to answer-name block; no dependencies
package ptrn_pkg;

  localparam logic [7:0] DotChar      = 8'h2E;
  localparam logic [2:0] WantDots     = 3'd5;
  localparam logic [2:0] DotsSat      = 3'd6;
  localparam logic [2:0] LenSlots     = 3'd5;
  localparam logic [2:0] CharLabels   = 3'd4;
  localparam logic [3:0] LastLabelLen = 4'd7;
  localparam logic [3:0] MaxOctetLen  = 4'd3;
  localparam logic [3:0] CountSat     = 4'd8;
  localparam logic [2:0] FallbackLast = 3'd4;
  localparam int         QueueDepth   = 2;

  typedef struct packed {
    logic             ok;
    logic [3:0][1:0]  lens;
    logic [11:0][7:0] chars;
  } answer_t;

  function automatic logic [7:0] fallback_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'd3;
      3'd1:    b = 8'h64;
      3'd2:    b = 8'h6E;
      3'd3:    b = 8'h73;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/ptrn_front.sv @@
// ptrn_front: parses the query name byte by byte, keeps label lengths and
// characters, and builds an answer descriptor on the last byte; uses ptrn_pkg
module ptrn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         name_byte,
  input  logic               last_byte,
  output logic               push,
  output ptrn_pkg::answer_t  push_entry
);

  logic [2:0]       dot_count;
  logic [2:0]       dot_count_next;
  logic [3:0]       char_count;
  logic [3:0]       char_count_next;
  logic [4:0][3:0]  label_lengths;
  logic [4:0][3:0]  label_lengths_next;
  logic [7:0]       label_chars [12];
  logic [11:0][7:0] chars_view;
  logic             wr_en;
  logic [3:0]       wr_idx;
  logic             short_ok;

  always_comb begin
    dot_count_next     = dot_count;
    char_count_next    = char_count;
    label_lengths_next = label_lengths;
    wr_en              = 1'b0;
    wr_idx             = {2'b00, dot_count[1:0]} * 4'd3 + {2'b00, char_count[1:0]};
    if (dot_count < ptrn_pkg::DotsSat) begin
      if (name_byte == ptrn_pkg::DotChar) begin
        if (dot_count < ptrn_pkg::LenSlots) begin
          label_lengths_next[dot_count] = char_count;
        end
        dot_count_next  = dot_count + 3'd1;
        char_count_next = 4'd0;
      end else begin
        if (dot_count < ptrn_pkg::CharLabels && char_count < ptrn_pkg::MaxOctetLen) begin
          wr_en = 1'b1;
        end
        if (char_count < ptrn_pkg::CountSat) begin
          char_count_next = char_count + 4'd1;
        end
      end
    end
  end

  always_comb begin
    short_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (label_lengths_next[i] > ptrn_pkg::MaxOctetLen) begin
        short_ok = 1'b0;
      end
      push_entry.lens[i] = label_lengths_next[i][1:0];
    end
    for (int i = 0; i < 12; i++) begin
      chars_view[i] = (wr_en && wr_idx == 4'(i)) ? name_byte : label_chars[i];
    end
    push_entry.chars = chars_view;
    push_entry.ok    = (dot_count_next == ptrn_pkg::WantDots) &&
                       (label_lengths_next[4] == ptrn_pkg::LastLabelLen) && short_ok;
  end

  assign push = take && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count     <= '0;
      char_count    <= '0;
      label_lengths <= '0;
    end else if (take) begin
      if (last_byte) begin
        dot_count     <= '0;
        char_count    <= '0;
        label_lengths <= '0;
      end else begin
        dot_count     <= dot_count_next;
        char_count    <= char_count_next;
        label_lengths <= label_lengths_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      label_chars[wr_idx] <= name_byte;
    end
  end

endmodule

@@ hw/rtl/ptrn_queue.sv @@
// ptrn_queue: short queue of answer descriptors between parser and emitter;
// uses ptrn_pkg
module ptrn_queue #(
  parameter int Depth = ptrn_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ptrn_pkg::answer_t  push_entry,
  output logic               full,
  output logic               head_valid,
  output ptrn_pkg::answer_t  head_entry,
  input  logic               pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ptrn_pkg::answer_t slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/ptrn_back.sv @@
// ptrn_back: walks the head descriptor and emits the answer name one byte per
// transfer through an output register; uses ptrn_pkg
module ptrn_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  ptrn_pkg::answer_t  head_entry,
  output logic               pop,
  output logic               ans_valid,
  input  logic               ans_stall,
  output logic [7:0]         out_byte,
  output logic               out_last,
  output logic               name_ok
);

  logic [1:0] lab;
  logic [1:0] pos;
  logic       term;
  logic [2:0] fidx;
  logic       emit;
  logic [7:0] byte_sel;
  logic       last_sel;
  logic [1:0] cur_len;
  logic [3:0] char_idx;

  assign emit     = head_valid && (!ans_valid || !ans_stall);
  assign cur_len  = head_entry.lens[lab];
  assign char_idx = {2'b00, lab} * 4'd3 + {2'b00, pos} - 4'd1;

  always_comb begin
    if (head_entry.ok) begin
      if (term) begin
        byte_sel = 8'd0;
        last_sel = 1'b1;
      end else if (pos == 2'd0) begin
        byte_sel = {6'd0, cur_len};
        last_sel = 1'b0;
      end else begin
        byte_sel = head_entry.chars[char_idx];
        last_sel = 1'b0;
      end
    end else begin
      byte_sel = ptrn_pkg::fallback_byte(fidx);
      last_sel = (fidx == ptrn_pkg::FallbackLast);
    end
  end

  assign pop = emit && last_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      lab  <= 2'd3;
      pos  <= 2'd0;
      term <= 1'b0;
      fidx <= 3'd0;
    end else if (emit) begin
      if (last_sel) begin
        lab  <= 2'd3;
        pos  <= 2'd0;
        term <= 1'b0;
        fidx <= 3'd0;
      end else if (head_entry.ok) begin
        if (pos == cur_len) begin
          pos <= 2'd0;
          if (lab == 2'd0) begin
            term <= 1'b1;
          end else begin
            lab <= lab - 2'd1;
          end
        end else begin
          pos <= pos + 2'd1;
        end
      end else begin
        fidx <= fidx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ans_valid <= 1'b0;
    end else if (emit) begin
      ans_valid <= 1'b1;
    end else if (!ans_stall) begin
      ans_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= last_sel;
      name_ok  <= head_entry.ok;
    end
  end

endmodule

@@ hw/rtl/ptr_name_to_answer_rdata.sv @@
// ptr_name_to_answer_rdata: top level, parser, descriptor queue and emitter
// depends on ptrn_pkg, ptrn_front, ptrn_queue, ptrn_back
//
// name channel: name_valid/name_stall carry one query-name byte per transfer,
// last_byte set on the final byte; one byte taken per cycle unless stalled
// ans channel: ans_valid/ans_stall carry the answer name, one byte per
// transfer; out_last marks the closing zero byte, name_ok is constant over
// one answer (0 means the fallback name 3,'d','n','s',0)
// the first answer byte passes the queue and the output register after the
// last name byte is taken; an answer runs one byte per cycle while ans_stall
// is low, 5 to 17 bytes, from the single byte-wide emitter on one descriptor
// a queue of QueueDepth descriptors sits between parser and emitter; the
// parser keeps taking bytes while answers drain, and name_stall is high
// only while that queue is full
// ans_stall holds the output register and the emitter; once the queue fills
// the name side stalls too
// reset (rst, synchronous) clears the counters, the queue pointers and the
// output valid flag; no clearing pass is needed
module ptr_name_to_answer_rdata #(
  parameter int QueueDepth = ptrn_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       name_valid,
  output logic       name_stall,
  input  logic [7:0] name_byte,
  input  logic       last_byte,
  output logic       ans_valid,
  input  logic       ans_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       name_ok
);

  logic              take;
  logic              push;
  logic              full;
  logic              head_valid;
  logic              pop;
  ptrn_pkg::answer_t push_entry;
  ptrn_pkg::answer_t head_entry;

  assign name_stall = full;
  assign take       = name_valid && !full;

  ptrn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .name_byte  (name_byte),
    .last_byte  (last_byte),
    .push       (push),
    .push_entry (push_entry)
  );

  ptrn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  ptrn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .ans_valid  (ans_valid),
    .ans_stall  (ans_stall),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .name_ok    (name_ok)
  );

  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    ans_valid && out_last |-> out_byte == 8'd0)
    else $error("answer terminator is not zero");

  a_fallback_nonzero: assert property (@(posedge clk) disable iff (rst)
    ans_valid && !name_ok && !out_last |-> out_byte != 8'd0)
    else $error("zero byte inside fallback name");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    take && last_byte |=> head_valid)
    else $error("finished name left no queued answer");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid && !(ans_valid && ans_stall))
    else $error("answer retired without a transfer slot");

endmodule
